[design/sobel_pkg.sv]
// ----------------------------------------------------------------------------
// sobel_pkg
// Shared types, register codes and the root-extraction step of the Sobel core.
// ----------------------------------------------------------------------------
`default_nettype none

package sobel_pkg;

    // Pixel and register widths
    localparam int PIX_W      = 8;
    localparam int WIDTH_W    = 11;
    localparam int HEIGHT_W   = 13;
    localparam int ROW_W      = 12;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 13;

    // Register indexes on the configuration channel
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_HEIGHT = 1'b1;

    // Reset values and limits
    localparam logic [WIDTH_W-1:0]  WIDTH_RST  = 11'd640;
    localparam logic [HEIGHT_W-1:0] HEIGHT_RST = 13'd480;
    localparam logic [WIDTH_W-1:0]  WIDTH_CAP  = 11'd1024;
    localparam logic [HEIGHT_W-1:0] HEIGHT_CAP = 13'd4096;
    localparam logic [ROW_W-1:0]    ROW_CAP    = 12'd4095;
    localparam logic [PIX_W-1:0]    PIX_MAX    = 8'd255;

    // Root extraction: two result bits per pipeline stage
    localparam int SQRT_STAGES = 4;

    // One line-memory word: the pixel two rows up and the pixel one row up
    typedef struct packed {
        logic [PIX_W-1:0] row_m2;
        logic [PIX_W-1:0] row_m1;
    } t_line_pair;

    // Payload of the read stage
    typedef struct packed {
        logic             res;
        logic             border;
        logic             last;
        logic [PIX_W-1:0] pix;
    } t_rd_stage;

    // Payload of the gradient stage
    typedef struct packed {
        logic             last;
        logic [PIX_W-1:0] x;
        logic [PIX_W-1:0] y;
    } t_grad_stage;

    // Payload of one root-extraction stage
    typedef struct packed {
        logic             last;
        logic             sat;
        logic [15:0]      val;
        logic [10:0]      rem;
        logic [PIX_W-1:0] root;
    } t_sqrt_stage;

    // Two steps of the digit-by-digit integer square root
    function automatic t_sqrt_stage sqrt_step2(input t_sqrt_stage s);
        t_sqrt_stage o;
        logic [10:0] rem;
        logic [10:0] trial;
        logic [7:0]  root;
        logic [15:0] v;
        o    = s;
        rem  = s.rem;
        root = s.root;
        v    = s.val;
        for (int i = 0; i < 2; i++) begin
            rem   = {rem[8:0], v[15:14]};
            v     = {v[13:0], 2'b00};
            trial = {1'b0, root, 2'b01};
            if (rem >= trial) begin
                rem  = rem - trial;
                root = {root[6:0], 1'b1};
            end else begin
                root = {root[6:0], 1'b0};
            end
        end
        o.rem  = rem;
        o.root = root;
        o.val  = v;
        return o;
    endfunction

endpackage

`default_nettype wire

[design/sobel_edge_magnitude_core.sv]
// A result is completed by the pixel accepted one row plus one pixel after its center pixel
//   (stream lag), then passes the read, gradient, square and four root stages and the output register.
// Throughput: one pixel per cycle; the whole pipeline holds while a result waits downstream.
// Reset (synchronous, active low): width 640, height 480, frame counters zero, pipeline empty.
//   Line memory and window are not cleared; every output uses only pixels of the current frame.
// ----------------------------------------------------------------------------
// sobel_edge_magnitude_core
// Streaming 3x3 Sobel gradient magnitude over raster-order 8-bit pixels.
// ----------------------------------------------------------------------------
`default_nettype none

module sobel_edge_magnitude_core
    import sobel_pkg::*;
#(
    parameter int MAX_WIDTH = 1024
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // Pixel input
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    input  wire logic [PIX_W-1:0]      s_axis_tdata,   // [7:0] pixel_in
    input  wire logic                  s_axis_tuser,   // [0] flush
    // Edge output
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    output logic [PIX_W-1:0]           m_axis_tdata,   // [7:0] edge_value
    output logic                       m_axis_tlast,   // frame_end
    // Register writes
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int AW = $clog2(MAX_WIDTH);   // line-memory address width
    localparam int EW = AW + 1;              // holds the effective width itself

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [WIDTH_W-1:0]  r_width;
    logic [HEIGHT_W-1:0] r_height;
    logic                cfg_wr;

    assign o_cfg_ready = 1'b1;
    assign cfg_wr      = i_cfg_valid & o_cfg_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= WIDTH_RST;
            r_height <= HEIGHT_RST;
        end else if (cfg_wr) begin
            unique case (i_cfg_index)
                CFG_IDX_WIDTH:  r_width  <= i_cfg_data[WIDTH_W-1:0];
                CFG_IDX_HEIGHT: r_height <= i_cfg_data[HEIGHT_W-1:0];
                default: ;
            endcase
        end
    end

    // Effective frame size: zero acts as one, large values saturate
    logic [WIDTH_W-1:0]  w_clip;
    logic [EW-1:0]       w_eff;
    logic [HEIGHT_W-1:0] h_eff;

    always_comb begin
        if (r_width == '0)            w_clip = WIDTH_W'(1);
        else if (r_width > WIDTH_CAP) w_clip = WIDTH_CAP;
        else                          w_clip = r_width;
        if (int'(w_clip) > MAX_WIDTH) w_eff = EW'(MAX_WIDTH);
        else                          w_eff = EW'(w_clip);

        if (r_height == '0)             h_eff = HEIGHT_W'(1);
        else if (r_height > HEIGHT_CAP) h_eff = HEIGHT_CAP;
        else                            h_eff = r_height;
    end

    // ------------------------------------------------------------------
    // Pipeline enable: everything advances together when the output
    // register is free or being drained
    // ------------------------------------------------------------------
    logic en;
    logic accept;
    logic r_out_vld;

    assign en            = ~r_out_vld | m_axis_tready;
    assign s_axis_tready = en;
    assign accept        = s_axis_tvalid & en;

    // ------------------------------------------------------------------
    // Stage 0: position counters, issue the line-memory read
    // ------------------------------------------------------------------
    logic [AW-1:0]    r_col;
    logic [ROW_W-1:0] r_row;
    logic [AW-1:0]    r_ocol;
    logic [ROW_W-1:0] r_orow;

    logic             col_wrap;
    logic             ocol_wrap;
    logic             orow_edge;
    logic             lagged;
    logic             border;
    logic             last;
    logic [AW-1:0]    n_col;
    logic [ROW_W-1:0] n_row;
    logic [AW-1:0]    n_ocol;
    logic [ROW_W-1:0] n_orow;

    always_comb begin
        col_wrap  = (EW'(r_col) + EW'(1)) >= w_eff;
        ocol_wrap = (EW'(r_ocol) + EW'(1)) >= w_eff;
        orow_edge = (HEIGHT_W'(r_orow) + HEIGHT_W'(1)) >= h_eff;

        // Results trail the input by one row plus one pixel
        lagged = (r_row >= ROW_W'(2)) || ((r_row == ROW_W'(1)) && (r_col != '0));
        border = (r_orow == '0) || (r_ocol == '0) || orow_edge || ocol_wrap;
        last   = ((HEIGHT_W'(r_orow) + HEIGHT_W'(1)) == h_eff) && ocol_wrap;

        n_col  = r_col;
        n_row  = r_row;
        n_ocol = r_ocol;
        n_orow = r_orow;
        if (accept) begin
            if (col_wrap) begin
                n_col = '0;
                if (r_row < ROW_CAP) n_row = r_row + ROW_W'(1);
            end else begin
                n_col = r_col + AW'(1);
            end
            if (lagged) begin
                if (ocol_wrap) begin
                    n_ocol = '0;
                    n_orow = r_orow + ROW_W'(1);
                end else begin
                    n_ocol = r_ocol + AW'(1);
                end
                // Last result of the frame: restart every counter
                if (last) begin
                    n_col  = '0;
                    n_row  = '0;
                    n_ocol = '0;
                    n_orow = '0;
                end
            end
        end
        // Any register write restarts the frame
        if (cfg_wr) begin
            n_col  = '0;
            n_row  = '0;
            n_ocol = '0;
            n_orow = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col  <= '0;
            r_row  <= '0;
            r_ocol <= '0;
            r_orow <= '0;
        end else begin
            r_col  <= n_col;
            r_row  <= n_row;
            r_ocol <= n_ocol;
            r_orow <= n_orow;
        end
    end

    // ------------------------------------------------------------------
    // Line memory: one word per column holds the two previous rows.
    // Read in stage 0, written back in stage 1.
    // ------------------------------------------------------------------
    t_line_pair r_line_mem [MAX_WIDTH];
    t_line_pair r_mem_q;
    t_line_pair r_fwd_data;
    logic       r_fwd;
    t_line_pair line_rd;
    t_line_pair wr_data;

    logic       r_s1_vld;
    t_rd_stage  r_s1;
    logic [AW-1:0] r_s1_addr;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_mem_q <= r_line_mem[r_col];
            if (r_s1_vld) r_line_mem[r_s1_addr] <= wr_data;
        end
    end

    // With a one-pixel row the same word is read while it is written back:
    // forward the new word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd <= 1'b0;
        end else if (en) begin
            r_fwd <= r_s1_vld && (r_s1_addr == r_col);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) r_fwd_data <= wr_data;
    end

    // Stage 0 -> 1 register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (en) begin
            r_s1_vld <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s1_addr   <= r_col;
            r_s1.res    <= lagged;
            r_s1.border <= border;
            r_s1.last   <= last;
            // Flush beats carry a zero pixel
            r_s1.pix    <= s_axis_tuser ? '0 : s_axis_tdata;
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: shift the 3x3 window, form and clamp both gradients
    // ------------------------------------------------------------------
    logic [PIX_W-1:0] r_win [9];    // [row*3 + col], row 0 top, col 0 left
    logic [PIX_W-1:0] q     [9];
    logic [9:0]       s_top;
    logic [9:0]       s_bot;
    logic [9:0]       s_lft;
    logic [9:0]       s_rgt;
    logic [10:0]      gx;
    logic [10:0]      gy;
    logic [PIX_W-1:0] ux;
    logic [PIX_W-1:0] uy;

    assign line_rd = r_fwd ? r_fwd_data : r_mem_q;

    always_comb begin
        wr_data.row_m2 = line_rd.row_m1;
        wr_data.row_m1 = r_s1.pix;

        for (int k = 0; k < 3; k++) begin
            q[k*3+0] = r_win[k*3+1];
            q[k*3+1] = r_win[k*3+2];
        end
        q[2] = line_rd.row_m2;
        q[5] = line_rd.row_m1;
        q[8] = r_s1.pix;

        s_top = 10'(q[0]) + {1'b0, q[1], 1'b0} + 10'(q[2]);
        s_bot = 10'(q[6]) + {1'b0, q[7], 1'b0} + 10'(q[8]);
        s_lft = 10'(q[0]) + {1'b0, q[3], 1'b0} + 10'(q[6]);
        s_rgt = 10'(q[2]) + {1'b0, q[5], 1'b0} + 10'(q[8]);
        gx    = {1'b0, s_bot} - {1'b0, s_top};
        gy    = {1'b0, s_rgt} - {1'b0, s_lft};

        // Clamp to 0..255
        if (gx[10])              ux = '0;
        else if (gx[9:8] != '0)  ux = PIX_MAX;
        else                     ux = gx[7:0];
        if (gy[10])              uy = '0;
        else if (gy[9:8] != '0)  uy = PIX_MAX;
        else                     uy = gy[7:0];
    end

    always_ff @(posedge i_clk) begin
        if (en && r_s1_vld) begin
            for (int k = 0; k < 9; k++) r_win[k] <= q[k];
        end
    end

    // Stage 1 -> 2: on the border both terms are the center pixel, so
    // x*x + y*y gives 2*p*p
    logic        r_s2_vld;
    t_grad_stage r_s2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_vld <= 1'b0;
        end else if (en) begin
            r_s2_vld <= r_s1_vld & r_s1.res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s2.last <= r_s1.last;
            r_s2.x    <= r_s1.border ? q[4] : ux;
            r_s2.y    <= r_s1.border ? q[4] : uy;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: sum of squares; stages 3..6: root, two bits per stage
    // ------------------------------------------------------------------
    logic [15:0]      sq_x;
    logic [15:0]      sq_y;
    logic [16:0]      sq_sum;
    logic             r_p_vld [SQRT_STAGES+1];
    t_sqrt_stage      r_p     [SQRT_STAGES+1];

    always_comb begin
        sq_x   = r_s2.x * r_s2.x;
        sq_y   = r_s2.y * r_s2.y;
        sq_sum = {1'b0, sq_x} + {1'b0, sq_y};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= SQRT_STAGES; k++) r_p_vld[k] <= 1'b0;
        end else if (en) begin
            r_p_vld[0] <= r_s2_vld;
            for (int k = 1; k <= SQRT_STAGES; k++) r_p_vld[k] <= r_p_vld[k-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_p[0].last <= r_s2.last;
            r_p[0].sat  <= sq_sum[16];    // root of 65536 or more saturates
            r_p[0].val  <= sq_sum[15:0];
            r_p[0].rem  <= '0;
            r_p[0].root <= '0;
            for (int k = 1; k <= SQRT_STAGES; k++) r_p[k] <= sqrt_step2(r_p[k-1]);
        end
    end

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    logic [PIX_W-1:0] r_out_edge;
    logic             r_out_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (en) begin
            r_out_vld <= r_p_vld[SQRT_STAGES];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out_edge <= r_p[SQRT_STAGES].sat ? PIX_MAX : r_p[SQRT_STAGES].root;
            r_out_last <= r_p[SQRT_STAGES].last;
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = r_out_edge;
    assign m_axis_tlast  = r_out_last;

endmodule

`default_nettype wire
